// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mlcfp_pkg.sv -----
`default_nettype none

package mlcfp_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam int MAGIC_BYTES = 4;
   localparam int HDR_END     = 12;
   localparam int CRC_BYTES   = 4;
   localparam int EXP_W       = 12;
   localparam int LEN_W       = 11;
   localparam int IDX_W       = 10;

   typedef enum logic [1:0] {
      OUT_NEED  = 2'd0,
      OUT_NOISE = 2'd1,
      OUT_ERROR = 2'd2,
      OUT_READY = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      ERR_OK      = 3'd0,
      ERR_TIMEOUT = 3'd1,
      ERR_BADLEN  = 3'd2,
      ERR_BADVER  = 3'd3,
      ERR_BADCRC  = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      CSR_MAGIC   = 2'd0,
      CSR_TIMEOUT = 2'd1,
      CSR_MAXLEN  = 2'd2,
      CSR_VERSION = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// ----- rtl/magic_length_crc32_frame_parser_core.sv -----
// Channel | Ports           | Direction | Word
// --------+-----------------+-----------+----------------------------------------
// req     | req_valid/stall | in        | rx_byte, now_ms
// rsp     | rsp_valid/stall | out       | outcome, last_error, payload, header
// csr     | csr_write       | in        | index 0..3, data up to 32 bits
//
// One word per cycle sustained while rsp_stall is low; each accepted word gives one
// result word (input register, then CRC byte update and framing compares into the
// result register).
// Reset clears framing state, result and input valid, and loads register defaults.
// rsp_stall holds the result; the input register keeps one more word, and
// req_stall rises only while both are full and the result is stalled.
`default_nettype none

module magic_length_crc32_frame_parser_core
   import mlcfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024,
   parameter int FRAME_BYTES = 1040
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [31:0] req_now_ms,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_outcome,
   output logic [2:0]       rsp_last_error,
   output logic             rsp_payload_valid,
   output logic [7:0]       rsp_payload_byte,
   output logic [9:0]       rsp_payload_index,
   output logic [7:0]       rsp_command_code,
   output logic [7:0]       rsp_flag_bits,
   output logic [7:0]       rsp_peer_status,
   output logic [15:0]      rsp_sequence_number,
   output logic [10:0]      rsp_body_length,

   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam int CMP_W = (CNT_W > EXP_W) ? CNT_W : EXP_W;
   localparam int SUM_W = CMP_W + 1;

   // configuration
   logic [31:0]      magic_word_ff;
   logic [31:0]      timeout_ms_ff;
   logic [LEN_W-1:0] max_payload_ff;
   logic [7:0]       protocol_version_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_word_ff       <= 32'd0;
         timeout_ms_ff       <= 32'd1000;
         max_payload_ff      <= LEN_W'(MAX_PAYLOAD);
         protocol_version_ff <= 8'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAGIC:   magic_word_ff       <= csr_wdata;
            CSR_TIMEOUT: timeout_ms_ff       <= csr_wdata;
            CSR_MAXLEN:  max_payload_ff      <= csr_wdata[LEN_W-1:0];
            CSR_VERSION: protocol_version_ff <= csr_wdata[7:0];
            default:     magic_word_ff       <= magic_word_ff;
         endcase
      end
   end

   // handshake
   logic in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_now_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_adv, fire, req_take;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_now_ff  <= req_now_ms;
      end
   end

   // framing state
   logic [CNT_W-1:0] frame_count_ff, frame_count_in;
   logic [EXP_W-1:0] expected_total_ff, expected_total_in;
   logic [31:0]      last_time_ff;
   err_type          error_code_ff, error_code_in;
   logic [31:0]      crc_running_ff, crc_running_in;
   logic [7:0]       header_ff [8];
   logic [31:0]      received_crc_ff, received_crc_in;
   logic             hdr_we;
   logic [2:0]       hdr_wa;

   // timeout restart
   logic [31:0]      gap;
   logic             timed_out;
   logic [CNT_W-1:0] cnt_e;
   logic [EXP_W-1:0] exp_e;
   logic [31:0]      crc_e;
   err_type          err_e;
   logic [31:0]      crc_upd;
   logic [SUM_W-1:0] pos_x, exp_x;
   logic [7:0]       magic_sel;
   logic [15:0]      len;
   logic [1:0]       crc_sel;

   assign gap       = in_now_ff - last_time_ff;
   assign timed_out = (frame_count_ff != '0) && (gap > timeout_ms_ff);
   assign cnt_e     = timed_out ? '0 : frame_count_ff;
   assign exp_e     = timed_out ? '0 : expected_total_ff;
   assign crc_e     = timed_out ? CRC_INIT : crc_running_ff;
   assign err_e     = timed_out ? ERR_TIMEOUT : error_code_ff;
   assign pos_x     = SUM_W'(cnt_e);
   assign exp_x     = SUM_W'(exp_e);
   assign magic_sel = magic_word_ff[{cnt_e[1:0], 3'b000} +: 8];
   assign len       = {in_byte_ff, header_ff[6]};
   assign crc_sel   = 2'(pos_x[1:0] - exp_x[1:0]);

   mlcfp_crc_byte u_crc (
      .crc_i  (crc_e),
      .data_i (in_byte_ff),
      .crc_o  (crc_upd)
   );

   outcome_type outcome_c;
   logic        pv_c;
   logic [7:0]  pb_c;
   logic [9:0]  pi_c;
   logic [7:0]  cmd_c, flg_c, sts_c;
   logic [15:0] seq_c;
   logic [10:0] plen_c;

   always_comb begin
      frame_count_in    = cnt_e;
      expected_total_in = exp_e;
      crc_running_in    = crc_e;
      error_code_in     = err_e;
      received_crc_in   = received_crc_ff;
      hdr_we            = 1'b0;
      hdr_wa            = 3'(pos_x[2:0] - 3'd4);
      outcome_c         = OUT_NEED;
      pv_c              = 1'b0;
      pb_c              = 8'd0;
      pi_c              = 10'd0;
      cmd_c             = 8'd0;
      flg_c             = 8'd0;
      sts_c             = 8'd0;
      seq_c             = 16'd0;
      plen_c            = 11'd0;

      if (pos_x < SUM_W'(MAGIC_BYTES)) begin
         if (in_byte_ff == magic_sel) begin
            frame_count_in = CNT_W'(cnt_e + 1'b1);
         end else begin
            // resync on the first magic byte
            frame_count_in    = (in_byte_ff == magic_word_ff[7:0]) ? CNT_W'(1) : '0;
            expected_total_in = '0;
            crc_running_in    = CRC_INIT;
            error_code_in     = ERR_OK;
            outcome_c         = OUT_NOISE;
         end
      end else if (pos_x >= SUM_W'(FRAME_BYTES)) begin
         frame_count_in    = '0;
         expected_total_in = '0;
         crc_running_in    = CRC_INIT;
         error_code_in     = ERR_BADLEN;
         outcome_c         = OUT_ERROR;
      end else begin
         frame_count_in = CNT_W'(cnt_e + 1'b1);
         if (pos_x < SUM_W'(HDR_END)) begin
            hdr_we         = 1'b1;
            crc_running_in = crc_upd;
         end else if (pos_x + SUM_W'(CRC_BYTES) < exp_x) begin
            crc_running_in = crc_upd;
            pv_c           = 1'b1;
            pb_c           = in_byte_ff;
            pi_c           = 10'(pos_x - SUM_W'(HDR_END));
         end else begin
            received_crc_in[{crc_sel, 3'b000} +: 8] = in_byte_ff;
         end

         if (pos_x == SUM_W'(HDR_END - 1)) begin
            if (len > 16'(max_payload_ff)) begin
               frame_count_in    = '0;
               expected_total_in = '0;
               crc_running_in    = CRC_INIT;
               error_code_in     = ERR_BADLEN;
               outcome_c         = OUT_ERROR;
            end else begin
               expected_total_in = EXP_W'(HDR_END + CRC_BYTES) + EXP_W'(len[LEN_W-1:0]);
            end
         end

         if (outcome_c == OUT_NEED && expected_total_in != '0 &&
             SUM_W'(frame_count_in) == SUM_W'(expected_total_in)) begin
            priority if (header_ff[0] != protocol_version_ff) begin
               error_code_in = ERR_BADVER;
               outcome_c     = OUT_ERROR;
            end else if ((crc_e ^ CRC_INIT) != received_crc_in) begin
               error_code_in = ERR_BADCRC;
               outcome_c     = OUT_ERROR;
            end else begin
               error_code_in = ERR_OK;
               outcome_c     = OUT_READY;
               cmd_c         = header_ff[1];
               flg_c         = header_ff[2];
               sts_c         = header_ff[3];
               seq_c         = {header_ff[5], header_ff[4]};
               plen_c        = {header_ff[7][2:0], header_ff[6]};
            end
            frame_count_in    = '0;
            expected_total_in = '0;
            crc_running_in    = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff    <= '0;
         expected_total_ff <= '0;
         last_time_ff      <= 32'd0;
         error_code_ff     <= ERR_OK;
         crc_running_ff    <= CRC_INIT;
      end else if (fire) begin
         frame_count_ff    <= frame_count_in;
         expected_total_ff <= expected_total_in;
         last_time_ff      <= in_now_ff;
         error_code_ff     <= error_code_in;
         crc_running_ff    <= crc_running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         received_crc_ff <= received_crc_in;
         if (hdr_we) begin
            header_ff[hdr_wa] <= in_byte_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_outcome         <= outcome_c;
         rsp_last_error      <= error_code_in;
         rsp_payload_valid   <= pv_c;
         rsp_payload_byte    <= pb_c;
         rsp_payload_index   <= pi_c;
         rsp_command_code    <= cmd_c;
         rsp_flag_bits       <= flg_c;
         rsp_peer_status     <= sts_c;
         rsp_sequence_number <= seq_c;
         rsp_body_length     <= plen_c;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPL(a_payload_not_final, clock, reset, rsp_valid && rsp_payload_valid, rsp_outcome == OUT_NEED, "payload word closed a frame")
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, SUM_W'(frame_count_ff) <= SUM_W'(FRAME_BYTES), "frame count past frame size")
   `ASSERT_IMPL(a_total_after_header, clock, reset, expected_total_ff != '0, SUM_W'(frame_count_ff) >= SUM_W'(HDR_END), "frame size set before header end")
   `ASSERT_NEXT(a_ready_clears_error, clock, reset, fire && outcome_c == OUT_READY, rsp_valid && rsp_last_error == ERR_OK, "ready word without ok status")

endmodule

`default_nettype wire

// ----- rtl/mlcfp_crc_byte.sv -----
`default_nettype none

module mlcfp_crc_byte
   import mlcfp_pkg::*;
(
   input  wire logic [31:0] crc_i,
   input  wire logic [7:0]  data_i,
   output logic      [31:0] crc_o
);

   always_comb begin
      logic [31:0] c;
      c = crc_i ^ {24'd0, data_i};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      crc_o = c;
   end

endmodule

`default_nettype wire
